// ===== src/crdg_pkg.sv =====
// ----------------------------------------------------------------------------
// crdg_pkg: shared constants and types of the camera ray direction generator
// Field widths, internal datapath widths and register index codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crdg_pkg;

    // Input and coefficient formats
    localparam int COORD_FRAC_BITS = 4;
    localparam int COEF_WIDTH      = 20;
    localparam int PIX_W           = 16;
    localparam int SIZE_W          = 13;
    localparam int ROW_W           = 3 * COEF_WIDTH;
    localparam int NDC_FRAC        = 16;

    // NDC quotient: floor(pixel * 2^(NDC_FRAC+1-COORD_FRAC_BITS) / size)
    localparam int QN_W   = PIX_W + NDC_FRAC + 1 - COORD_FRAC_BITS;
    localparam int NDC_W  = QN_W + 1;

    // Matrix product and magnitude
    localparam int PROD_W = COEF_WIDTH + NDC_W;
    localparam int T_W    = PROD_W + 2;
    localparam int MAG_W  = T_W - 1;

    // The largest normalized magnitude sits in [2^(NORM_W-1), 2^NORM_W)
    localparam int NORM_W    = 30;
    localparam int NORM_LEAD = NORM_W - 1;
    localparam int GRP_N     = (MAG_W + 7) / 8;
    localparam int MSB_W     = $clog2(GRP_N * 8);

    // Square root
    localparam int SQ_W   = 2 * NORM_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int SREM_W = ROOT_W + 2;

    // Output direction, signed Q1.15
    localparam int DIR_W    = 16;
    localparam int DIR_FRAC = 15;
    localparam int NUM_W    = NORM_W + DIR_FRAC + 1;
    localparam logic [DIR_W-1:0] DIR_ONE     = DIR_W'(1) << DIR_FRAC;
    localparam logic [DIR_W-1:0] DIR_POS_MAX = DIR_ONE - DIR_W'(1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_Z    = 3'd4;

    // Per-ray side information carried along the normalization pipe
    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } ray_tag_t;

endpackage

// ===== src/crdg_ndc_div.sv =====
// ----------------------------------------------------------------------------
// crdg_ndc_div: pipelined pixel to NDC quotient divider
// One restoring quotient bit per stage for both coordinates in parallel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crdg_ndc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [crdg_pkg::PIX_W-1:0]    in_px,
    input  logic [crdg_pkg::PIX_W-1:0]    in_py,
    input  logic [crdg_pkg::SIZE_W-1:0]   width,
    input  logic [crdg_pkg::SIZE_W-1:0]   height,
    output logic                          out_valid,
    output logic [crdg_pkg::QN_W-1:0]     out_qx,
    output logic [crdg_pkg::QN_W-1:0]     out_qy
);

    localparam int N   = crdg_pkg::QN_W;
    localparam int PW  = crdg_pkg::PIX_W;
    localparam int SW  = crdg_pkg::SIZE_W;
    localparam int PAD = N - PW;

    logic [SW-1:0] div_x;
    logic [SW-1:0] div_y;

    logic          valid_reg [0:N-1];
    logic [PW-1:0] px_reg    [0:N-1];
    logic [PW-1:0] py_reg    [0:N-1];
    logic [SW-1:0] rx_reg    [0:N-1];
    logic [SW-1:0] ry_reg    [0:N-1];
    logic [N-1:0]  qx_reg    [0:N-1];
    logic [N-1:0]  qy_reg    [0:N-1];

    // Treat a zero size as one
    assign div_x = (width  == '0) ? SW'(1) : width;
    assign div_y = (height == '0) ? SW'(1) : height;

    for (genvar g = 0; g < N; g++)
    begin : g_stage
        logic          v_src;
        logic [PW-1:0] px_src;
        logic [PW-1:0] py_src;
        logic [SW-1:0] rx_src;
        logic [SW-1:0] ry_src;
        logic [N-1:0]  qx_src;
        logic [N-1:0]  qy_src;
        logic [N-1:0]  dvd_x;
        logic [N-1:0]  dvd_y;
        logic [SW:0]   tx;
        logic [SW:0]   ty;
        logic          gx;
        logic          gy;
        logic [SW-1:0] rx_next;
        logic [SW-1:0] ry_next;

        if (g == 0)
        begin : g_first
            assign v_src  = in_valid;
            assign px_src = in_px;
            assign py_src = in_py;
            assign rx_src = '0;
            assign ry_src = '0;
            assign qx_src = '0;
            assign qy_src = '0;
        end
        else
        begin : g_next
            assign v_src  = valid_reg[g-1];
            assign px_src = px_reg[g-1];
            assign py_src = py_reg[g-1];
            assign rx_src = rx_reg[g-1];
            assign ry_src = ry_reg[g-1];
            assign qx_src = qx_reg[g-1];
            assign qy_src = qy_reg[g-1];
        end

        // Bring down the next dividend bit and try a subtract
        assign dvd_x   = {px_src, {PAD{1'b0}}};
        assign dvd_y   = {py_src, {PAD{1'b0}}};
        assign tx      = {rx_src, dvd_x[N-1-g]};
        assign ty      = {ry_src, dvd_y[N-1-g]};
        assign gx      = (tx >= {1'b0, div_x});
        assign gy      = (ty >= {1'b0, div_y});
        assign rx_next = gx ? SW'(tx - {1'b0, div_x}) : tx[SW-1:0];
        assign ry_next = gy ? SW'(ty - {1'b0, div_y}) : ty[SW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                px_reg[g] <= px_src;
                py_reg[g] <= py_src;
                rx_reg[g] <= rx_next;
                ry_reg[g] <= ry_next;
                qx_reg[g] <= {qx_src[N-2:0], gx};
                qy_reg[g] <= {qy_src[N-2:0], gy};
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_qx    = qx_reg[N-1];
    assign out_qy    = qy_reg[N-1];

endmodule

// ===== src/crdg_xform.sv =====
// ----------------------------------------------------------------------------
// crdg_xform: NDC to camera matrix transform
// Multiply stage, accumulate stage, then sign and magnitude split.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crdg_xform
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [crdg_pkg::QN_W-1:0]             in_qx,
    input  logic [crdg_pkg::QN_W-1:0]             in_qy,
    input  logic [crdg_pkg::ROW_W-1:0]            row_x,
    input  logic [crdg_pkg::ROW_W-1:0]            row_y,
    input  logic [crdg_pkg::ROW_W-1:0]            row_z,
    output logic                                  out_valid,
    output logic [2:0][crdg_pkg::MAG_W-1:0]       out_mag,
    output logic [2:0]                            out_neg
);

    localparam int CW = crdg_pkg::COEF_WIDTH;
    localparam int NW = crdg_pkg::NDC_W;
    localparam int PW = crdg_pkg::PROD_W;
    localparam int TW = crdg_pkg::T_W;
    localparam int MW = crdg_pkg::MAG_W;

    logic [2:0][crdg_pkg::ROW_W-1:0] rows;
    logic signed [NW-1:0]            nx;
    logic signed [NW-1:0]            ny;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic signed [PW-1:0] pa_reg [0:2];
    logic signed [PW-1:0] pb_reg [0:2];
    logic signed [TW-1:0] t_reg  [0:2];
    logic [2:0][MW-1:0]   mag_reg;
    logic [2:0]           neg_reg;

    assign rows = {row_z, row_y, row_x};

    // Shift quotients down by one to center the viewport on zero
    assign nx = {1'b0, in_qx} - (NW'(1) << crdg_pkg::NDC_FRAC);
    assign ny = {1'b0, in_qy} - (NW'(1) << crdg_pkg::NDC_FRAC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        logic signed [CW-1:0] ca;
        logic signed [CW-1:0] cb;
        logic signed [CW-1:0] cc;
        logic signed [TW-1:0] t_next;
        logic [TW-1:0]        abs_next;

        assign ca = rows[r][0 +: CW];
        assign cb = rows[r][CW +: CW];
        assign cc = rows[r][2*CW +: CW];

        // Sum both products with the constant column
        assign t_next   = TW'(pa_reg[r]) + TW'(pb_reg[r])
                        + (TW'(cc) <<< crdg_pkg::NDC_FRAC);
        assign abs_next = t_reg[r][TW-1] ? (TW'(0) - t_reg[r]) : t_reg[r];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg[r]  <= ca * nx;
                pb_reg[r]  <= cb * ny;
                t_reg[r]   <= t_next;
                mag_reg[r] <= abs_next[MW-1:0];
                neg_reg[r] <= t_reg[r][TW-1];
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;

endmodule

// ===== src/crdg_norm.sv =====
// ----------------------------------------------------------------------------
// crdg_norm: common magnitude scaling
// Finds the largest magnitude, locates its leading one in two levels and
// shifts all three magnitudes so that the largest lands in [2^29, 2^30).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crdg_norm
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [2:0][crdg_pkg::MAG_W-1:0]       in_mag,
    input  logic [2:0]                            in_neg,
    output logic                                  out_valid,
    output logic [2:0][crdg_pkg::NORM_W-1:0]      out_mag,
    output crdg_pkg::ray_tag_t                    out_tag
);

    localparam int MW = crdg_pkg::MAG_W;
    localparam int OW = crdg_pkg::NORM_W;
    localparam int NG = crdg_pkg::GRP_N;
    localparam int SB = crdg_pkg::MSB_W;
    localparam int LD = crdg_pkg::NORM_LEAD;

    logic [MW-1:0]     max01;
    logic [MW-1:0]     max_all;
    logic [NG*8-1:0]   max_pad;
    logic [NG-1:0]     grp_nz;
    logic [2:0]        grp_pos [0:NG-1];
    logic [SB-1:0]     msb_next;

    logic [3:0]              v_reg;
    logic [MW-1:0]           s1_max_reg;
    logic [2:0][MW-1:0]      s1_mag_reg;
    logic [2:0][MW-1:0]      s2_mag_reg;
    logic [2:0][MW-1:0]      s3_mag_reg;
    logic [2:0]              s1_neg_reg;
    logic [2:0]              s2_neg_reg;
    logic [2:0]              s3_neg_reg;
    logic [NG-1:0]           s2_nz_reg;
    logic [2:0]              s2_pos_reg [0:NG-1];
    logic [SB-1:0]           s3_msb_reg;
    logic                    s3_zero_reg;
    logic [2:0][OW-1:0]      s4_mag_reg;
    crdg_pkg::ray_tag_t      s4_tag_reg;

    // Largest of the three magnitudes
    assign max01   = (in_mag[1] > in_mag[0]) ? in_mag[1] : in_mag[0];
    assign max_all = (in_mag[2] > max01) ? in_mag[2] : max01;

    // Leading one inside each byte group
    assign max_pad = (NG*8)'(s1_max_reg);
    always_comb
    begin
        for (int j = 0; j < NG; j++)
        begin
            grp_nz[j]  = |max_pad[j*8 +: 8];
            grp_pos[j] = 3'd0;
            for (int k = 0; k < 8; k++)
            begin
                if (max_pad[j*8+k])
                begin
                    grp_pos[j] = 3'(k);
                end
            end
        end
    end

    // Highest nonzero group gives the leading one position
    always_comb
    begin
        msb_next = '0;
        for (int j = 0; j < NG; j++)
        begin
            if (s2_nz_reg[j])
            begin
                msb_next = SB'(j * 8) + SB'(s2_pos_reg[j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_max_reg  <= max_all;
            s1_mag_reg  <= in_mag;
            s1_neg_reg  <= in_neg;
            s2_nz_reg   <= grp_nz;
            s2_mag_reg  <= s1_mag_reg;
            s2_neg_reg  <= s1_neg_reg;
            s3_msb_reg  <= msb_next;
            s3_zero_reg <= ~|s2_nz_reg;
            s3_mag_reg  <= s2_mag_reg;
            s3_neg_reg  <= s2_neg_reg;
            s4_tag_reg  <= '{zero: s3_zero_reg, neg: s3_neg_reg};
        end
    end

    for (genvar j = 0; j < NG; j++)
    begin : g_grp
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s2_pos_reg[j] <= grp_pos[j];
            end
        end
    end

    // Common shift, right shift truncates
    for (genvar r = 0; r < 3; r++)
    begin : g_shift
        logic [MW-1:0] sh_next;

        always_comb
        begin
            if (s3_msb_reg >= SB'(LD))
            begin
                sh_next = s3_mag_reg[r] >> (s3_msb_reg - SB'(LD));
            end
            else
            begin
                sh_next = s3_mag_reg[r] << (SB'(LD) - s3_msb_reg);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s4_mag_reg[r] <= sh_next[OW-1:0];
            end
        end
    end

    assign out_valid = v_reg[3];
    assign out_mag   = s4_mag_reg;
    assign out_tag   = s4_tag_reg;

endmodule

// ===== src/crdg_sqrt.sv =====
// ----------------------------------------------------------------------------
// crdg_sqrt: vector length
// Squares, sum, then a digit-by-digit integer square root, one root bit
// per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crdg_sqrt
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [2:0][crdg_pkg::NORM_W-1:0]      in_mag,
    input  crdg_pkg::ray_tag_t                    in_tag,
    output logic                                  out_valid,
    output logic [2:0][crdg_pkg::NORM_W-1:0]      out_mag,
    output crdg_pkg::ray_tag_t                    out_tag,
    output logic [crdg_pkg::ROOT_W-1:0]           out_root
);

    localparam int OW = crdg_pkg::NORM_W;
    localparam int QW = crdg_pkg::SQ_W;
    localparam int SW = crdg_pkg::SUM_W;
    localparam int RW = crdg_pkg::ROOT_W;
    localparam int EW = crdg_pkg::SREM_W;

    logic               va_reg;
    logic               vb_reg;
    logic [QW-1:0]      sq_reg [0:2];
    logic [2:0][OW-1:0] a_mag_reg;
    logic [2:0][OW-1:0] b_mag_reg;
    crdg_pkg::ray_tag_t a_tag_reg;
    crdg_pkg::ray_tag_t b_tag_reg;
    logic [SW-1:0]      sum_reg;

    logic               valid_reg [0:RW-1];
    logic [SW-1:0]      s_sum_reg [0:RW-1];
    logic [EW-1:0]      rem_reg   [0:RW-1];
    logic [RW-1:0]      root_reg  [0:RW-1];
    logic [2:0][OW-1:0] mag_reg   [0:RW-1];
    crdg_pkg::ray_tag_t tag_reg   [0:RW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    // Square each component, then add
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sq_reg[r] <= QW'(in_mag[r]) * QW'(in_mag[r]);
            end
            a_mag_reg <= in_mag;
            a_tag_reg <= in_tag;
            sum_reg   <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            b_mag_reg <= a_mag_reg;
            b_tag_reg <= a_tag_reg;
        end
    end

    for (genvar g = 0; g < RW; g++)
    begin : g_stage
        logic               v_src;
        logic [SW-1:0]      sum_src;
        logic [EW-1:0]      rem_src;
        logic [RW-1:0]      root_src;
        logic [2:0][OW-1:0] mag_src;
        crdg_pkg::ray_tag_t tag_src;
        logic [EW+1:0]      tr;
        logic [EW+1:0]      trial;
        logic               ge;

        if (g == 0)
        begin : g_first
            assign v_src    = vb_reg;
            assign sum_src  = sum_reg;
            assign rem_src  = '0;
            assign root_src = '0;
            assign mag_src  = b_mag_reg;
            assign tag_src  = b_tag_reg;
        end
        else
        begin : g_next
            assign v_src    = valid_reg[g-1];
            assign sum_src  = s_sum_reg[g-1];
            assign rem_src  = rem_reg[g-1];
            assign root_src = root_reg[g-1];
            assign mag_src  = mag_reg[g-1];
            assign tag_src  = tag_reg[g-1];
        end

        // Bring down the next bit pair and test root*4+1
        assign tr    = {rem_src, sum_src[SW-1-2*g -: 2]};
        assign trial = (EW+2)'({root_src, 2'b01});
        assign ge    = (tr >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_sum_reg[g] <= sum_src;
                rem_reg[g]   <= ge ? EW'(tr - trial) : EW'(tr);
                root_reg[g]  <= {root_src[RW-2:0], ge};
                mag_reg[g]   <= mag_src;
                tag_reg[g]   <= tag_src;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_mag   = mag_reg[RW-1];
    assign out_tag   = tag_reg[RW-1];
    assign out_root  = root_reg[RW-1];

endmodule

// ===== src/crdg_rdiv.sv =====
// ----------------------------------------------------------------------------
// crdg_rdiv: component by length divider
// Rounded quotient mag*2^15/n, one bit per stage for all three lanes,
// then sign, saturation and the zero vector case.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crdg_rdiv
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [2:0][crdg_pkg::NORM_W-1:0]      in_mag,
    input  crdg_pkg::ray_tag_t                    in_tag,
    input  logic [crdg_pkg::ROOT_W-1:0]           in_root,
    output logic                                  out_valid,
    output logic [2:0][crdg_pkg::DIR_W-1:0]       out_dir,
    output logic                                  out_degenerate
);

    localparam int OW = crdg_pkg::NORM_W;
    localparam int RW = crdg_pkg::ROOT_W;
    localparam int DW = crdg_pkg::DIR_W;
    localparam int UW = crdg_pkg::NUM_W;

    logic               p_v_reg;
    logic [2:0][RW-1:0] p_rem_reg;
    logic [2:0][DW-1:0] p_lo_reg;
    logic [RW-1:0]      p_root_reg;
    crdg_pkg::ray_tag_t p_tag_reg;

    logic               valid_reg [0:DW-1];
    logic [2:0][RW-1:0] rem_reg   [0:DW-1];
    logic [2:0][DW-1:0] lo_reg    [0:DW-1];
    logic [2:0][DW-1:0] q_reg     [0:DW-1];
    logic [RW-1:0]      root_reg  [0:DW-1];
    crdg_pkg::ray_tag_t tag_reg   [0:DW-1];

    logic               o_v_reg;
    logic [2:0][DW-1:0] o_dir_reg;
    logic               o_deg_reg;
    logic [2:0][DW-1:0] dir_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p_v_reg <= in_valid;
            o_v_reg <= valid_reg[DW-1];
        end
    end

    // Form mag*2^15 + n/2 and split off the part already below n
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                p_rem_reg[r] <= RW'(((UW'(in_mag[r]) << crdg_pkg::DIR_FRAC)
                                   + UW'(in_root >> 1)) >> DW);
                p_lo_reg[r]  <= DW'((UW'(in_mag[r]) << crdg_pkg::DIR_FRAC)
                                   + UW'(in_root >> 1));
            end
            p_root_reg <= in_root;
            p_tag_reg  <= in_tag;
        end
    end

    for (genvar g = 0; g < DW; g++)
    begin : g_stage
        logic               v_src;
        logic [2:0][RW-1:0] rem_src;
        logic [2:0][DW-1:0] lo_src;
        logic [2:0][DW-1:0] q_src;
        logic [RW-1:0]      root_src;
        crdg_pkg::ray_tag_t tag_src;
        logic [2:0][RW-1:0] rem_next;
        logic [2:0]         ge;

        if (g == 0)
        begin : g_first
            assign v_src    = p_v_reg;
            assign rem_src  = p_rem_reg;
            assign lo_src   = p_lo_reg;
            assign q_src    = '0;
            assign root_src = p_root_reg;
            assign tag_src  = p_tag_reg;
        end
        else
        begin : g_next
            assign v_src    = valid_reg[g-1];
            assign rem_src  = rem_reg[g-1];
            assign lo_src   = lo_reg[g-1];
            assign q_src    = q_reg[g-1];
            assign root_src = root_reg[g-1];
            assign tag_src  = tag_reg[g-1];
        end

        // Restoring step on each lane
        always_comb
        begin
            for (int r = 0; r < 3; r++)
            begin
                ge[r]       = ({rem_src[r], lo_src[r][DW-1-g]} >= {1'b0, root_src});
                rem_next[r] = ge[r] ? RW'({rem_src[r], lo_src[r][DW-1-g]} - {1'b0, root_src})
                                    : RW'({rem_src[r], lo_src[r][DW-1-g]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                lo_reg[g]   <= lo_src;
                root_reg[g] <= root_src;
                tag_reg[g]  <= tag_src;
                for (int r = 0; r < 3; r++)
                begin
                    q_reg[g][r] <= {q_src[r][DW-2:0], ge[r]};
                end
            end
        end
    end

    // Apply sign, clip positive values to +1 - 1 lsb and negative ones to -1, force zero for a null vector
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            logic [DW-1:0] qc;
            qc = (q_reg[DW-1][r] > crdg_pkg::DIR_ONE) ? crdg_pkg::DIR_ONE : q_reg[DW-1][r];
            if (tag_reg[DW-1].zero)
            begin
                dir_next[r] = '0;
            end
            else if (tag_reg[DW-1].neg[r])
            begin
                dir_next[r] = DW'(0) - qc;
            end
            else
            begin
                dir_next[r] = (qc > crdg_pkg::DIR_POS_MAX) ? crdg_pkg::DIR_POS_MAX : qc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_dir_reg <= dir_next;
            o_deg_reg <= tag_reg[DW-1].zero;
        end
    end

    assign out_valid      = o_v_reg;
    assign out_dir        = o_dir_reg;
    assign out_degenerate = o_deg_reg;

endmodule

// ===== src/camera_ray_direction_generator.sv =====
// ----------------------------------------------------------------------------
// camera_ray_direction_generator: primary ray direction per pixel
// Pixel position to unit world-space direction through a loaded 3x3 matrix.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock and returns one direction beat per pixel,
// in order. A pixel passes through 88 register stages, the first of which
// captures the pixel: 29 stages of NDC division, 31 stages of square root
// and 16 stages of the final divide, plus twelve stages of multiply, add,
// scaling, squaring, rounding setup, sign and the output buffer. The whole
// pipe moves as one; a two-beat output buffer lets it keep taking pixels
// while a result waits, and it only halts once that buffer is full and not
// drained. Load configuration only while no pixel is in flight.
`timescale 1ns / 1ps

module camera_ray_direction_generator
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crdg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [crdg_pkg::ROW_W-1:0]          cfg_data,
    // Pixel stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,   // pixel_x, pixel_y
    // Direction stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [47:0]                         m_axis_tdata,   // dir_x, dir_y, dir_z
    output logic                                m_axis_tuser    // degenerate
);

    localparam int PW = crdg_pkg::PIX_W;
    localparam int DW = crdg_pkg::DIR_W;
    localparam int OB = 3 * DW + 1;

    logic [crdg_pkg::SIZE_W-1:0] width_reg;
    logic [crdg_pkg::SIZE_W-1:0] height_reg;
    logic [crdg_pkg::ROW_W-1:0]  row_x_reg;
    logic [crdg_pkg::ROW_W-1:0]  row_y_reg;
    logic [crdg_pkg::ROW_W-1:0]  row_z_reg;

    logic                               en;
    logic                               div_valid;
    logic [crdg_pkg::QN_W-1:0]          div_qx;
    logic [crdg_pkg::QN_W-1:0]          div_qy;
    logic                               xf_valid;
    logic [2:0][crdg_pkg::MAG_W-1:0]    xf_mag;
    logic [2:0]                         xf_neg;
    logic                               nm_valid;
    logic [2:0][crdg_pkg::NORM_W-1:0]   nm_mag;
    crdg_pkg::ray_tag_t                 nm_tag;
    logic                               sq_valid;
    logic [2:0][crdg_pkg::NORM_W-1:0]   sq_mag;
    crdg_pkg::ray_tag_t                 sq_tag;
    logic [crdg_pkg::ROOT_W-1:0]        sq_root;
    logic                               rd_valid;
    logic [2:0][DW-1:0]                 rd_dir;
    logic                               rd_deg;

    logic [OB-1:0] buf_reg [0:1];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic          push;
    logic          pop;

    // Register writes, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= crdg_pkg::SIZE_W'(1);
            height_reg <= crdg_pkg::SIZE_W'(1);
            row_x_reg  <= '0;
            row_y_reg  <= '0;
            row_z_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                crdg_pkg::REG_VIEWPORT_WIDTH:  width_reg  <= cfg_data[crdg_pkg::SIZE_W-1:0];
                crdg_pkg::REG_VIEWPORT_HEIGHT: height_reg <= cfg_data[crdg_pkg::SIZE_W-1:0];
                crdg_pkg::REG_MATRIX_ROW_X:    row_x_reg  <= cfg_data;
                crdg_pkg::REG_MATRIX_ROW_Y:    row_y_reg  <= cfg_data;
                crdg_pkg::REG_MATRIX_ROW_Z:    row_z_reg  <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Advance the pipe unless the output buffer is full and held
    assign en            = (cnt_reg != 2'd2) || m_axis_tready;
    assign s_axis_tready = en;

    crdg_ndc_div u_ndc_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_px     (s_axis_tdata[PW-1:0]),
        .in_py     (s_axis_tdata[2*PW-1:PW]),
        .width     (width_reg),
        .height    (height_reg),
        .out_valid (div_valid),
        .out_qx    (div_qx),
        .out_qy    (div_qy)
    );

    crdg_xform u_xform
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_qx     (div_qx),
        .in_qy     (div_qy),
        .row_x     (row_x_reg),
        .row_y     (row_y_reg),
        .row_z     (row_z_reg),
        .out_valid (xf_valid),
        .out_mag   (xf_mag),
        .out_neg   (xf_neg)
    );

    crdg_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xf_valid),
        .in_mag    (xf_mag),
        .in_neg    (xf_neg),
        .out_valid (nm_valid),
        .out_mag   (nm_mag),
        .out_tag   (nm_tag)
    );

    crdg_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid),
        .in_mag    (nm_mag),
        .in_tag    (nm_tag),
        .out_valid (sq_valid),
        .out_mag   (sq_mag),
        .out_tag   (sq_tag),
        .out_root  (sq_root)
    );

    crdg_rdiv u_rdiv
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (sq_valid),
        .in_mag         (sq_mag),
        .in_tag         (sq_tag),
        .in_root        (sq_root),
        .out_valid      (rd_valid),
        .out_dir        (rd_dir),
        .out_degenerate (rd_deg)
    );

    // Two-beat output buffer
    assign push     = en && rd_valid;
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ push;
            rd_ptr_reg <= rd_ptr_reg ^ pop;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= {rd_deg, rd_dir[2], rd_dir[1], rd_dir[0]};
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = buf_reg[rd_ptr_reg][3*DW-1:0];
    assign m_axis_tuser  = buf_reg[rd_ptr_reg][3*DW];

endmodule

// ===== src/crdg_checker.sv =====
// ----------------------------------------------------------------------------
// crdg_checker: port-level checks of the ray direction generator
// Output handshake rules and the meaning of the degenerate flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crdg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // Hold a stalled beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // A null vector gives a zero direction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
        else $error("degenerate beat with nonzero direction");

    // A unit vector always has some nonzero component
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != 48'd0)
        else $error("zero direction without degenerate flag");

endmodule

bind camera_ray_direction_generator crdg_checker u_crdg_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/camera_ray_direction_checker.sv =====
// ----------------------------------------------------------------------------
// camera_ray_direction_checker: direction predictor and scoreboard
// Mirrors configuration writes, predicts each pixel's direction and compares
// every direction beat against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_ray_direction_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [crdg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crdg_pkg::ROW_W-1:0]      cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [47:0]                     m_axis_tdata,
    input  logic                            m_axis_tuser,
    output int                              fail_count,
    output int                              pending_dirs,
    output int                              checked_dirs,
    output int                              degenerate_dirs
);

    typedef struct packed {
        logic        degenerate;
        logic [15:0] dz;
        logic [15:0] dy;
        logic [15:0] dx;
    } ray_dir_t;

    logic [crdg_pkg::SIZE_W-1:0] vp_width, vp_height;
    logic [crdg_pkg::ROW_W-1:0]  rows [3];
    ray_dir_t                    expected_dirs [$];

    function automatic longint ndc_of(logic [15:0] pos, logic [crdg_pkg::SIZE_W-1:0] size);
        longint unsigned den;
        den = (size == 0 ? 64'd1 : 64'(size)) << crdg_pkg::COORD_FRAC_BITS;
        return longint'((64'(pos) << 17) / den) - 65536;
    endfunction

    function automatic longint coef(logic [crdg_pkg::ROW_W-1:0] row, int k);
        logic signed [crdg_pkg::COEF_WIDTH-1:0] c;
        c = row[k*crdg_pkg::COEF_WIDTH +: crdg_pkg::COEF_WIDTH];
        return longint'(c);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic ray_dir_t predict_dir(logic [15:0] px, logic [15:0] py);
        longint          nx, ny, t;
        longint unsigned mag [3];
        longint unsigned m, sum, n, q;
        logic            neg [3];
        logic [15:0]     comp [3];
        ray_dir_t        r;
        nx = ndc_of(px, vp_width);
        ny = ndc_of(py, vp_height);
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            t = coef(rows[i], 0) * nx + coef(rows[i], 1) * ny + coef(rows[i], 2) * 65536;
            neg[i] = t < 0;
            mag[i] = neg[i] ? -t : t;
            if (mag[i] > m) m = mag[i];
        end
        r = '0;
        if (m == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        // bring the largest magnitude into [2^29, 2^30)
        while (m >= (64'd1 << 30))
        begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
        n = isqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] * 32768 + n / 2) / n;
            if (q > 32768) q = 32768;
            if (neg[i])
                comp[i] = -16'(q);
            else
                comp[i] = (q > 32767) ? 16'h7fff : 16'(q);
        end
        r.dx = comp[0];
        r.dy = comp[1];
        r.dz = comp[2];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    // Track configuration, predict on pixel beats, compare on direction beats
    always @(posedge clk or negedge rst_n)
    begin
        ray_dir_t e, g;
        if (!rst_n)
        begin
            vp_width <= 1;
            vp_height <= 1;
            rows[0] <= '0;
            rows[1] <= '0;
            rows[2] <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    crdg_pkg::REG_VIEWPORT_WIDTH:
                        vp_width <= cfg_data[crdg_pkg::SIZE_W-1:0];
                    crdg_pkg::REG_VIEWPORT_HEIGHT:
                        vp_height <= cfg_data[crdg_pkg::SIZE_W-1:0];
                    crdg_pkg::REG_MATRIX_ROW_X: rows[0] <= cfg_data;
                    crdg_pkg::REG_MATRIX_ROW_Y: rows[1] <= cfg_data;
                    crdg_pkg::REG_MATRIX_ROW_Z: rows[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_dirs.push_back(predict_dir(s_axis_tdata[15:0], s_axis_tdata[31:16]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                g = {m_axis_tuser, m_axis_tdata};
                if (expected_dirs.size() == 0)
                    report_mismatch("unexpected beat", g[47:0], '0);
                else
                begin
                    e = expected_dirs.pop_front();
                    checked_dirs++;
                    if (e.degenerate) degenerate_dirs++;
                    if (g.dx != e.dx) report_mismatch("dir_x", 48'(g.dx), 48'(e.dx));
                    if (g.dy != e.dy) report_mismatch("dir_y", 48'(g.dy), 48'(e.dy));
                    if (g.dz != e.dz) report_mismatch("dir_z", 48'(g.dz), 48'(e.dz));
                    if (g.degenerate != e.degenerate)
                        report_mismatch("degenerate", 48'(g.degenerate), 48'(e.degenerate));
                end
            end
        end
        pending_dirs = expected_dirs.size();
    end

    initial
    begin
        fail_count = 0;
        pending_dirs = 0;
        checked_dirs = 0;
        degenerate_dirs = 0;
    end

endmodule

// ===== sim/camera_ray_direction_generator_tb.sv =====
// ----------------------------------------------------------------------------
// camera_ray_direction_generator_tb: regression bench for the ray generator
// Loads several viewport and matrix settings, streams directed and random
// pixels under varying backpressure and lets the checker judge each ray.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_ray_direction_generator_tb;

    localparam int LATENCY     = 87;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IW          = crdg_pkg::CFG_IDX_W;
    localparam int RW          = crdg_pkg::ROW_W;
    localparam int CW          = crdg_pkg::COEF_WIDTH;

    logic                 clk, rst_n;
    logic                 cfg_valid, cfg_ready;
    logic [IW-1:0]        cfg_index;
    logic [RW-1:0]        cfg_data;
    logic                 s_axis_tvalid, s_axis_tready;
    logic [31:0]          s_axis_tdata;
    logic                 m_axis_tvalid, m_axis_tready;
    logic [47:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    int                   fail_count, pending_dirs, checked_dirs, degenerate_dirs;
    int                   cycle_count;
    int                   send_idle_pct, recv_idle_pct;
    logic                 hold_off;

    camera_ray_direction_generator dut (.*);
    camera_ray_direction_checker checker_i (.*);

    always
    begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // Stop on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drain directions with random stalls or a long hold-off
    always @(posedge clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

    task automatic write_reg(logic [IW-1:0] idx, logic [RW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(logic [15:0] px, logic [15:0] py);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_dirs != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_coef();
        case ($urandom_range(5))
            0: return 20'h80000;
            1: return 20'h7ffff;
            2: return '0;
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic [RW-1:0] rand_row();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    task automatic load_setting(logic [12:0] w, logic [12:0] h,
                                logic [RW-1:0] rx, logic [RW-1:0] ry,
                                logic [RW-1:0] rz);
        write_reg(crdg_pkg::REG_VIEWPORT_WIDTH, RW'(w));
        write_reg(crdg_pkg::REG_VIEWPORT_HEIGHT, RW'(h));
        write_reg(crdg_pkg::REG_MATRIX_ROW_X, rx);
        write_reg(crdg_pkg::REG_MATRIX_ROW_Y, ry);
        write_reg(crdg_pkg::REG_MATRIX_ROW_Z, rz);
    endtask

    task automatic random_pixels(int count, int w, int h);
        logic [15:0] px, py;
        for (int i = 0; i < count; i++)
        begin
            // mostly inside the viewport, sometimes anywhere
            if ($urandom_range(9) < 8)
            begin
                px = 16'($urandom_range(w * 16));
                py = 16'($urandom_range(h * 16));
            end
            else
            begin
                px = 16'($urandom);
                py = 16'($urandom);
            end
            send_pixel(px, py);
        end
    endtask

    initial
    begin
        int w, h;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cycle_count = 0;
        hold_off = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 45;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset matrix gives the zero vector
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hffff, 16'hffff);
        drain();

        // Directed: zero viewport size, unknown index, extreme coefficients
        load_setting(13'd0, 13'd4096, {20'h10000, 20'h00000, 20'h10000},
                     {20'h00000, 20'h10000, 20'h10000}, {20'h80000, 20'h7ffff, 20'h7ffff});
        write_reg(IW'(7), '1);
        write_reg(IW'(5), '1);
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hffff, 16'h0000);
        send_pixel(16'h0000, 16'hffff);
        send_pixel(16'h0010, 16'h8000);
        send_pixel(16'h0008, 16'hffff);
        send_pixel(16'haaaa, 16'h5555);
        send_pixel(16'h5555, 16'haaaa);
        drain();
        // Cancelling rows: the z term cancels at pixel_y zero, the center maps onto the z axis
        load_setting(13'd2, 13'd2, {20'h0, 20'h0, 20'h10000},
                     {20'h0, 20'h0, 20'h0}, {20'h10000, 20'h10000, 20'h0});
        send_pixel(16'h0010, 16'h0010);
        send_pixel(16'h0020, 16'h0000);
        send_pixel(16'h0000, 16'h0020);
        drain();
        load_setting(13'd4096, 13'd1, '1, {20'h7ffff, 20'h7ffff, 20'h7ffff},
                     {20'h80000, 20'h80000, 20'h80000});
        send_pixel(16'hffff, 16'hffff);
        send_pixel(16'h8000, 16'h0008);
        send_pixel(16'h0001, 16'h0001);
        drain();

        // Random phases across idle profiles
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 3) begin send_idle_pct = 45; recv_idle_pct = 7; end
            if (phase == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
            w = (phase % 3 == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4096);
            h = (phase == 7) ? 4096 : $urandom_range(1, 4096);
            load_setting(13'(w), 13'(h), rand_row(), rand_row(), rand_row());
            if (phase == 6)
            begin
                // hold the output back long enough to fill the pipe
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            random_pixels(200, w, h);
            drain();
        end

        $display("checked %0d directions over 11 matrix settings, %0d degenerate",
                 checked_dirs, degenerate_dirs);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
